FILE: rtl/core/assert_macros.svh
// Assertion macros used by the RTL of the pixel blend core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication under reset
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication under reset
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/core/swkpb_pkg.sv
// Types, register codes and arithmetic helpers for the soft white key pixel blend
`default_nettype none

package swkpb_pkg;

    typedef struct packed {
        logic [7:0] fg_luma;
        logic [7:0] fg_blue_diff;
        logic [7:0] fg_red_diff;
        logic [7:0] bg_luma;
        logic [7:0] bg_blue_diff;
        logic [7:0] bg_red_diff;
        logic       frame_end;
    } pix_in_t;

    typedef struct packed {
        logic [7:0] out_luma;
        logic [7:0] out_blue_diff;
        logic [7:0] out_red_diff;
        logic       out_frame_end;
    } pix_out_t;

    localparam int unsigned CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOFTNESS   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GLOW_GAIN  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RIM_CHROMA = 8'd3;

    localparam logic [7:0] THRESHOLD_RST  = 8'd220;
    localparam logic [7:0] SOFTNESS_RST   = 8'd24;
    localparam logic [7:0] GLOW_GAIN_RST  = 8'd0;
    localparam logic [7:0] RIM_CHROMA_RST = 8'd0;

    // Reciprocal of the ramp width: ceil(2^RECIP_SHIFT / width)
    localparam int unsigned RECIP_SHIFT = 24;
    localparam int unsigned DIV_STEPS   = RECIP_SHIFT;
    localparam logic [RECIP_SHIFT-1:0] DIVIDEND = {RECIP_SHIFT{1'b1}};

    function automatic logic [15:0] mul8(input logic [7:0] a, input logic [7:0] b);
        mul8 = {8'b0, a} * {8'b0, b};
    endfunction

    // Rounded weighted sum before the /255
    function automatic logic [15:0] mix_sum(input logic [15:0] p0, input logic [15:0] p1);
        mix_sum = p0 + p1 + 16'd127;
    endfunction

    // Exact floor(x / 255) for x below 65280
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + {9'b0, x[15:8]} + 17'd1;
        div255 = t[15:8];
    endfunction

    function automatic logic [7:0] dist128(input logic [7:0] v);
        dist128 = v[7] ? {1'b0, v[6:0]} : 8'(8'd128 - v);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/soft_white_key_pixel_blend.sv
// Top level of the soft white key pixel blend pipeline
`default_nettype none
`include "assert_macros.svh"

// Takes one foreground/background YCbCr pixel pair per clock while busy is low and
// returns the blended pixel from the stage 8 output register, marked by result_valid
// for exactly one cycle; the receiver cannot stall, so results must be taken as
// they come. Throughput is one pixel per clock while busy is low, through an
// eight-stage pipeline. After reset, and after every write to threshold or softness,
// busy stays high while a bit-serial divider (one quotient bit per cycle) forms the
// reciprocal of the ramp width; writes to the glow and rim chroma strengths take
// effect at once. The configuration channel is always ready.
module soft_white_key_pixel_blend
    import swkpb_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire pix_in_t              pixel,
    output logic                      result_valid,
    output pix_out_t                  result,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]           cfg_data
);

    localparam int unsigned NSTAGE = 8;
    localparam int unsigned CNT_W  = $clog2(DIV_STEPS);

    // Configuration registers
    logic [7:0] thr_reg, soft_reg, glow_reg, chr_reg;
    logic       cfg_wr;
    logic       ramp_wr;

    // Ramp bounds and reciprocal divider
    logic [9:0]             lo_wide, hi_wide;
    logic [7:0]             cfg_lo, cfg_wid;
    logic [7:0]             lo_reg, wid_reg, rem_reg;
    logic [RECIP_SHIFT-1:0] quo_reg;
    logic [RECIP_SHIFT:0]   recip_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic                   load_reg, act_reg;
    logic [8:0]             trial;
    logic                   trial_ge;
    logic [7:0]             rem_next;
    logic [RECIP_SHIFT-1:0] quo_next;

    // Pipeline valid bits
    logic [NSTAGE-1:0] v_reg;

    // Stage 1: ramp position
    logic [8:0]        chroma_sum;
    logic signed [10:0] white, ramp_pos;
    logic              s1_zero_next, s1_full_next;
    logic [7:0]        s1_m_reg;
    logic              s1_zero_reg, s1_full_reg;
    pix_in_t           s1_pix_reg;

    // Stage 2: key quotient
    logic [15:0]       s2_num;
    logic [40:0]       s2_prod;
    logic [7:0]        s2_q_reg;
    logic              s2_zero_reg, s2_full_reg;
    pix_in_t           s2_pix_reg;

    // Stage 3: blend products
    logic [7:0]        key_next, key_inv;
    logic [15:0]       s3_yf_reg, s3_yb_reg, s3_cbf_reg, s3_cbb_reg;
    logic [15:0]       s3_crf_reg, s3_crb_reg, s3_rim_reg;
    logic [7:0]        s3_bcb_reg, s3_bcr_reg;
    logic              s3_fe_reg;

    // Stage 4: blended channels and rim weight
    logic [7:0]        s4_y_reg, s4_cb_reg, s4_cr_reg, s4_rim_reg, s4_bcb_reg, s4_bcr_reg;
    logic              s4_fe_reg;

    // Stage 5: rim products
    logic [15:0]       s5_gp_reg, s5_cp_reg;
    logic [7:0]        s5_y_reg, s5_cb_reg, s5_cr_reg, s5_bcb_reg, s5_bcr_reg;
    logic              s5_fe_reg;

    // Stage 6: glow and rim chroma weight
    logic [7:0]        s6_gadd_reg, s6_cq_reg;
    logic [7:0]        s6_y_reg, s6_cb_reg, s6_cr_reg, s6_bcb_reg, s6_bcr_reg;
    logic              s6_fe_reg;

    // Stage 7: rim chroma products and glowing luma
    logic [7:0]        cq_inv;
    logic [15:0]       s7_cbf_reg, s7_cbb_reg, s7_crf_reg, s7_crb_reg;
    logic [8:0]        s7_y_reg;
    logic              s7_fe_reg;

    // Stage 8: output
    pix_out_t          res_reg;

    assign cfg_ready    = 1'b1;
    assign cfg_wr       = cfg_valid && cfg_ready;
    assign ramp_wr      = cfg_wr && (cfg_index == CFG_THRESHOLD || cfg_index == CFG_SOFTNESS);
    assign busy         = load_reg || act_reg;
    assign result_valid = v_reg[NSTAGE-1];
    assign result       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= THRESHOLD_RST;
            soft_reg <= SOFTNESS_RST;
            glow_reg <= GLOW_GAIN_RST;
            chr_reg  <= RIM_CHROMA_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                CFG_THRESHOLD:  thr_reg  <= cfg_data;
                CFG_SOFTNESS:   soft_reg <= cfg_data;
                CFG_GLOW_GAIN:  glow_reg <= cfg_data;
                CFG_RIM_CHROMA: chr_reg  <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Clamp the ramp ends and keep the width at least one
    always_comb
    begin
        lo_wide = {2'b0, thr_reg} - {2'b0, soft_reg};
        hi_wide = {2'b0, thr_reg} + {2'b0, soft_reg};
        if (lo_wide[9])
            lo_wide = 10'd0;
        if (hi_wide > 10'd255)
            hi_wide = 10'd255;
        if (hi_wide <= lo_wide)
            hi_wide = lo_wide + 10'd1;
        cfg_lo  = lo_wide[7:0];
        cfg_wid = 8'(hi_wide - lo_wide);
    end

    // One restoring step of 2^24-1 divided by the width
    always_comb
    begin
        trial    = {rem_reg, quo_reg[RECIP_SHIFT-1]};
        trial_ge = trial >= {1'b0, wid_reg};
        rem_next = trial_ge ? 8'(trial - {1'b0, wid_reg}) : trial[7:0];
        quo_next = {quo_reg[RECIP_SHIFT-2:0], trial_ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_reg <= 1'b1;
            act_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (ramp_wr)
                load_reg <= 1'b1;
            else if (load_reg)
                load_reg <= 1'b0;

            if (load_reg)
            begin
                act_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (act_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                    act_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_reg)
        begin
            lo_reg  <= cfg_lo;
            wid_reg <= cfg_wid;
            rem_reg <= '0;
            quo_reg <= DIVIDEND;
        end
        else if (act_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                recip_reg <= {1'b0, quo_next} + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[NSTAGE-2:0], start && !busy};
    end

    // Stage 1: whiteness and its place on the ramp
    always_comb
    begin
        chroma_sum   = {1'b0, dist128(pixel.fg_blue_diff)} + {1'b0, dist128(pixel.fg_red_diff)};
        white        = $signed({3'b0, pixel.fg_luma}) - $signed({1'b0, chroma_sum, 1'b0});
        ramp_pos     = white - $signed({3'b0, lo_reg});
        s1_zero_next = ramp_pos[10] || (ramp_pos == 11'sd0);
        s1_full_next = !s1_zero_next && (ramp_pos[7:0] >= wid_reg);
    end

    always_ff @(posedge clk)
    begin
        s1_m_reg    <= ramp_pos[7:0];
        s1_zero_reg <= s1_zero_next;
        s1_full_reg <= s1_full_next;
        s1_pix_reg  <= pixel;
    end

    // Stage 2: (pos * 255) / width by reciprocal
    always_comb
    begin
        s2_num  = {s1_m_reg, 8'b0} - {8'b0, s1_m_reg};
        s2_prod = {25'b0, s2_num} * {16'b0, recip_reg};
    end

    always_ff @(posedge clk)
    begin
        s2_q_reg    <= s2_prod[RECIP_SHIFT+7:RECIP_SHIFT];
        s2_zero_reg <= s1_zero_reg;
        s2_full_reg <= s1_full_reg;
        s2_pix_reg  <= s1_pix_reg;
    end

    // Stage 3: clamp the key, form the blend products
    always_comb
    begin
        case ({s2_zero_reg, s2_full_reg})
            2'b10:   key_next = 8'd0;
            2'b01:   key_next = 8'd255;
            default: key_next = s2_q_reg;
        endcase
        key_inv = 8'd255 - key_next;
    end

    always_ff @(posedge clk)
    begin
        s3_yf_reg  <= mul8(s2_pix_reg.fg_luma, key_inv);
        s3_yb_reg  <= mul8(s2_pix_reg.bg_luma, key_next);
        s3_cbf_reg <= mul8(s2_pix_reg.fg_blue_diff, key_inv);
        s3_cbb_reg <= mul8(s2_pix_reg.bg_blue_diff, key_next);
        s3_crf_reg <= mul8(s2_pix_reg.fg_red_diff, key_inv);
        s3_crb_reg <= mul8(s2_pix_reg.bg_red_diff, key_next);
        s3_rim_reg <= mul8(key_next, key_inv);
        s3_bcb_reg <= s2_pix_reg.bg_blue_diff;
        s3_bcr_reg <= s2_pix_reg.bg_red_diff;
        s3_fe_reg  <= s2_pix_reg.frame_end;
    end

    // Stage 4: rounded /255
    always_ff @(posedge clk)
    begin
        s4_y_reg   <= div255(mix_sum(s3_yf_reg, s3_yb_reg));
        s4_cb_reg  <= div255(mix_sum(s3_cbf_reg, s3_cbb_reg));
        s4_cr_reg  <= div255(mix_sum(s3_crf_reg, s3_crb_reg));
        s4_rim_reg <= div255(mix_sum(s3_rim_reg, 16'd0));
        s4_bcb_reg <= s3_bcb_reg;
        s4_bcr_reg <= s3_bcr_reg;
        s4_fe_reg  <= s3_fe_reg;
    end

    // Stage 5: weight the rim by glow and chroma strength
    always_ff @(posedge clk)
    begin
        s5_gp_reg  <= mul8(s4_rim_reg, glow_reg);
        s5_cp_reg  <= mul8(s4_rim_reg, chr_reg);
        s5_y_reg   <= s4_y_reg;
        s5_cb_reg  <= s4_cb_reg;
        s5_cr_reg  <= s4_cr_reg;
        s5_bcb_reg <= s4_bcb_reg;
        s5_bcr_reg <= s4_bcr_reg;
        s5_fe_reg  <= s4_fe_reg;
    end

    // Stage 6: a zero strength gives a zero term, so no bypass is needed
    always_ff @(posedge clk)
    begin
        s6_gadd_reg <= div255(mix_sum(s5_gp_reg, 16'd0));
        s6_cq_reg   <= div255(mix_sum(s5_cp_reg, 16'd0));
        s6_y_reg    <= s5_y_reg;
        s6_cb_reg   <= s5_cb_reg;
        s6_cr_reg   <= s5_cr_reg;
        s6_bcb_reg  <= s5_bcb_reg;
        s6_bcr_reg  <= s5_bcr_reg;
        s6_fe_reg   <= s5_fe_reg;
    end

    // Stage 7: second chroma blend products and glowing luma
    assign cq_inv = 8'd255 - s6_cq_reg;

    always_ff @(posedge clk)
    begin
        s7_cbf_reg <= mul8(s6_cb_reg, cq_inv);
        s7_cbb_reg <= mul8(s6_bcb_reg, s6_cq_reg);
        s7_crf_reg <= mul8(s6_cr_reg, cq_inv);
        s7_crb_reg <= mul8(s6_bcr_reg, s6_cq_reg);
        s7_y_reg   <= {1'b0, s6_y_reg} + {1'b0, s6_gadd_reg};
        s7_fe_reg  <= s6_fe_reg;
    end

    // Stage 8: saturate luma; chroma stays within range by construction
    always_ff @(posedge clk)
    begin
        res_reg.out_luma      <= s7_y_reg[8] ? 8'd255 : s7_y_reg[7:0];
        res_reg.out_blue_diff <= div255(mix_sum(s7_cbf_reg, s7_cbb_reg));
        res_reg.out_red_diff  <= div255(mix_sum(s7_crf_reg, s7_crb_reg));
        res_reg.out_frame_end <= s7_fe_reg;
    end

    `ASSERT_NXT(a_request_enters, clk, rst_n, start && !busy, v_reg[0])
    `ASSERT_IMP(a_divider_busy, clk, rst_n, act_reg || load_reg, busy && !(start && !busy))
    `ASSERT_NXT(a_ramp_write_busy, clk, rst_n, ramp_wr, busy)
    `ASSERT_IMP(a_key_flags, clk, rst_n, v_reg[0], !(s1_zero_reg && s1_full_reg))
    `ASSERT_IMP(a_div_count, clk, rst_n, act_reg, cnt_reg <= CNT_W'(DIV_STEPS - 1))

endmodule

`default_nettype wire

FILE: sim/tb.sv
// Self-checking testbench for the soft white key pixel blend: random and directed pixels
`timescale 1ns / 1ps

module tb;
    import swkpb_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNMAPPED = 8'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LAST     = 8'hFF;
    localparam int unsigned STALL_LIMIT   = 5000;
    localparam int unsigned DRAIN_CYCLES  = 16;
    localparam int unsigned RANDOM_PHASES = 12;
    localparam int unsigned PHASE_ITEMS   = 100;
    localparam int unsigned GAP_PERCENT   = 12;

    class key_blend_tracker;
        logic [7:0]  threshold;
        logic [7:0]  softness;
        logic [7:0]  glow_gain;
        logic [7:0]  rim_chroma;
        pix_out_t    expected_blends[$];
        int unsigned mismatches;

        function new();
            threshold  = 8'd220;
            softness   = 8'd24;
            glow_gain  = 8'd0;
            rim_chroma = 8'd0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
            case (idx)
                CFG_THRESHOLD:  threshold  = val;
                CFG_SOFTNESS:   softness   = val;
                CFG_GLOW_GAIN:  glow_gain  = val;
                CFG_RIM_CHROMA: rim_chroma = val;
                default: ;  // unmapped index: drop the write
            endcase
        endfunction

        function int chroma_offset(int v);
            return (v < 128) ? 128 - v : v - 128;
        endfunction

        function int weighted_mix(int a, int b, int k);
            return (a * (255 - k) + b * k + 127) / 255;
        endfunction

        function logic [7:0] clamp8(int v);
            if (v < 0)
                return 8'd0;
            if (v > 255)
                return 8'd255;
            return 8'(v);
        endfunction

        function pix_out_t blend_pixel(pix_in_t p);
            int       lo;
            int       hi;
            int       white;
            int       key;
            int       rim;
            int       cq;
            int       oy;
            int       ocb;
            int       ocr;
            pix_out_t r;
            lo = int'(threshold) - int'(softness);
            hi = int'(threshold) + int'(softness);
            if (lo < 0)
                lo = 0;
            if (hi > 255)
                hi = 255;
            // keep the ramp at least one step wide
            if (hi <= lo)
                hi = lo + 1;
            white = int'(p.fg_luma)
                    - 2 * (chroma_offset(int'(p.fg_blue_diff))
                           + chroma_offset(int'(p.fg_red_diff)));
            key = ((white - lo) * 255) / (hi - lo);
            if (key < 0)
                key = 0;
            else if (key > 255)
                key = 255;
            oy  = weighted_mix(int'(p.fg_luma), int'(p.bg_luma), key);
            ocb = weighted_mix(int'(p.fg_blue_diff), int'(p.bg_blue_diff), key);
            ocr = weighted_mix(int'(p.fg_red_diff), int'(p.bg_red_diff), key);
            rim = (key * (255 - key) + 127) / 255;
            if (glow_gain != 8'd0)
                oy += (rim * int'(glow_gain) + 127) / 255;
            if (rim_chroma != 8'd0)
            begin
                cq  = (rim * int'(rim_chroma) + 127) / 255;
                ocb = weighted_mix(ocb, int'(p.bg_blue_diff), cq);
                ocr = weighted_mix(ocr, int'(p.bg_red_diff), cq);
            end
            r.out_luma      = clamp8(oy);
            r.out_blue_diff = clamp8(ocb);
            r.out_red_diff  = clamp8(ocr);
            r.out_frame_end = p.frame_end;
            return r;
        endfunction

        function void note_pixel(pix_in_t p);
            expected_blends.push_back(blend_pixel(p));
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got)
            begin
                $display("%0t: %s expected %0d got %0d", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_blended(pix_out_t got);
            pix_out_t want;
            if (expected_blends.size() == 0)
            begin
                $display("%0t: unexpected result expected none got %h", $time, got);
                mismatches++;
                return;
            end
            want = expected_blends.pop_front();
            compare_field("out_luma", want.out_luma, got.out_luma);
            compare_field("out_blue_diff", want.out_blue_diff, got.out_blue_diff);
            compare_field("out_red_diff", want.out_red_diff, got.out_red_diff);
            compare_field("out_frame_end", 8'(want.out_frame_end), 8'(got.out_frame_end));
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    pix_in_t              pixel;
    logic                 result_valid;
    pix_out_t             result;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0]           cfg_data;

    key_blend_tracker blends = new();
    bit               gaps_on;
    int unsigned      quiet_cycles = 0;

    soft_white_key_pixel_blend DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic pix_in_t make_pixel(int y, int cb, int cr, int by, int bcb, int bcr,
                                           bit fe);
        pix_in_t p;
        p.fg_luma      = 8'(y);
        p.fg_blue_diff = 8'(cb);
        p.fg_red_diff  = 8'(cr);
        p.bg_luma      = 8'(by);
        p.bg_blue_diff = 8'(bcb);
        p.bg_red_diff  = 8'(bcr);
        p.frame_end    = fe;
        return p;
    endfunction

    function automatic pix_in_t random_pixel();
        pix_in_t p;
        p = 49'({$urandom(), $urandom()});
        // mostly near-neutral chroma so whiteness lands on the ramp
        if ($urandom_range(99) < 60)
        begin
            p.fg_blue_diff = 8'(120 + $urandom_range(16));
            p.fg_red_diff  = 8'(120 + $urandom_range(16));
            if ($urandom_range(9) == 0)
            begin
                p.fg_blue_diff = 8'd128;
                p.fg_red_diff  = 8'd128;
            end
        end
        p.frame_end = ($urandom_range(15) == 0);
        return p;
    endfunction

    task automatic idle_cycle();
        @(negedge clk);
        start = 1'b0;
        pixel = random_pixel();
    endtask

    task automatic send_pixel(input pix_in_t p);
        if (gaps_on)
            while ($urandom_range(99) < GAP_PERCENT)
                idle_cycle();
        @(negedge clk);
        start = 1'b1;
        pixel = p;
        do
            @(posedge clk);
        while (busy);
        blends.note_pixel(p);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do
            @(posedge clk);
        while (!cfg_ready);
        blends.set_reg(idx, val);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // drop start and wait for the pipeline and the divider to empty
    task automatic settle();
        @(negedge clk);
        start = 1'b0;
        while (blends.expected_blends.size() != 0 || busy)
            @(posedge clk);
    endtask

    task automatic apply_settings(input logic [7:0] thr, input logic [7:0] half_width,
                                  input logic [7:0] glow, input logic [7:0] chr);
        settle();
        write_reg(CFG_THRESHOLD, thr);
        write_reg(CFG_SOFTNESS, half_width);
        write_reg(CFG_GLOW_GAIN, glow);
        write_reg(CFG_RIM_CHROMA, chr);
    endtask

    task automatic directed_phase(input logic [7:0] thr, input logic [7:0] half_width,
                                  input logic [7:0] glow, input logic [7:0] chr);
        apply_settings(thr, half_width, glow, chr);
        send_pixel(make_pixel(thr, 128, 128, $urandom_range(255), $urandom_range(255),
                              $urandom_range(255), 1'b0));
        send_pixel(random_pixel());
    endtask

    task automatic random_settings();
        logic [7:0] thr;
        logic [7:0] half_width;
        logic [7:0] glow;
        logic [7:0] chr;
        if ($urandom_range(3) == 0)
            thr = ($urandom_range(1) == 1) ? 8'd255 : 8'd0;
        else
            thr = 8'($urandom_range(255));
        case ($urandom_range(7))
            0:       half_width = 8'd0;
            1:       half_width = 8'd1;
            2:       half_width = 8'd128;
            3:       half_width = 8'd255;
            default: half_width = 8'($urandom_range(128, 1));
        endcase
        glow = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(255));
        chr  = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(255));
        if ($urandom_range(7) == 0)
            glow = 8'd255;
        if ($urandom_range(7) == 0)
            chr = 8'd255;
        apply_settings(thr, half_width, glow, chr);
        if ($urandom_range(3) == 0)
            write_reg(8'($urandom_range(255, 4)), 8'($urandom_range(255)));
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid)
                blends.check_blended(result);
            if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        pixel     = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        gaps_on   = 1'b1;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: ramp 196..244
        send_pixel(make_pixel(0, 0, 0, 0, 0, 0, 1'b0));
        send_pixel(make_pixel(255, 255, 255, 255, 255, 255, 1'b1));
        send_pixel(make_pixel(255, 128, 128, 16, 128, 128, 1'b0));
        send_pixel(make_pixel(220, 128, 128, 40, 90, 200, 1'b0));
        send_pixel(make_pixel(196, 128, 128, 255, 0, 255, 1'b0));
        send_pixel(make_pixel(244, 128, 128, 0, 255, 0, 1'b1));
        send_pixel(make_pixel(230, 130, 126, 100, 100, 100, 1'b0));
        send_pixel(make_pixel(0, 0, 255, 200, 60, 60, 1'b0));
        send_pixel(make_pixel(255, 255, 0, 10, 20, 30, 1'b0));
        send_pixel(make_pixel(210, 127, 129, 255, 255, 255, 1'b1));

        // low ramp end clamped at zero, full rim terms, unmapped indexes ignored
        apply_settings(8'd10, 8'd50, 8'd255, 8'd255);
        write_reg(CFG_IDX_UNMAPPED, 8'd0);
        write_reg(CFG_IDX_LAST, 8'd1);
        send_pixel(make_pixel(20, 128, 128, 0, 255, 0, 1'b0));
        send_pixel(make_pixel(40, 128, 128, 255, 0, 255, 1'b1));
        // high end clamped at 255, glow only
        directed_phase(8'd250, 8'd50, 8'd128, 8'd0);
        // empty ramp at the bottom and at the top
        directed_phase(8'd0, 8'd0, 8'd0, 8'd255);
        directed_phase(8'd255, 8'd0, 8'd255, 8'd0);
        // softness beyond its nominal range
        directed_phase(8'd128, 8'd255, 8'd64, 8'd64);
        directed_phase(8'd255, 8'd255, 8'd0, 8'd0);
        directed_phase(8'd0, 8'd128, 8'd1, 8'd1);

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            // hold start high while the middle phases send their pixels
            gaps_on = (ph < 4 || ph > 6);
            random_settings();
            repeat (PHASE_ITEMS) send_pixel(random_pixel());
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (blends.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/swkpb_pkg.sv
rtl/core/soft_white_key_pixel_blend.sv
sim/tb.sv
